// File: rtl/core/pfde_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the page framebuffer draw engine.
// No dependencies; imported by the engine top level.
package pfde_pkg;

   // payload field widths
   localparam int KIND_W = 3;
   localparam int X_W    = 7;
   localparam int Y_W    = 6;
   localparam int PAGE_W = 3;
   localparam int DATA_W = 8;
   localparam int MODE_W = 2;

   // command codes
   typedef enum logic [KIND_W-1:0] {
      KIND_PIXEL = 3'd0,
      KIND_VBAR  = 3'd1,
      KIND_HBAR  = 3'd2,
      KIND_CLEAR = 3'd3,
      KIND_READ  = 3'd4
   } kind_type;

   // draw mode codes; the spare code behaves as set
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SET    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_INVERT = 2'd2;

   // mask building
   localparam logic [DATA_W-1:0] FULL_MASK     = 8'hFF;
   localparam logic [DATA_W:0]   BOT_MASK_SEED = 9'h002;
   localparam logic [DATA_W:0]   BOT_MASK_ONE  = 9'h001;

   // combine a mask with a stored byte as the mode selects
   function automatic logic [DATA_W-1:0] apply_mode(logic [MODE_W-1:0] mode,
                                                     logic [DATA_W-1:0] old_byte,
                                                     logic [DATA_W-1:0] mask);
      logic [DATA_W-1:0] res;
      case (mode)
         MODE_CLEAR:  res = old_byte & ~mask;
         MODE_INVERT: res = old_byte ^ mask;
         default:     res = old_byte | mask;
      endcase
      return res;
   endfunction

endpackage

// File: rtl/core/pfde_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pfde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/page_framebuffer_draw_engine.sv
`timescale 1ns / 1ps
// Top level of the page framebuffer draw engine: command sequencer and RMW datapath.
// Depends on pfde_pkg and pfde_ram.
//
// Usage
//   A COLUMNS x (8*PAGES) monochrome store, kept as PAGES pages of COLUMNS
//   column bytes in one RAM (bit 0 = top row of a page). Commands arrive on
//   the req_ channel (valid/stall) and each gives exactly one transfer on
//   the rsp_ channel: the stored byte for a read, zero for everything else.
//   csr_wr_en writes the draw mode (clear, set, invert) and is taken on any
//   cycle; change it only while the engine is idle.
// Timing
//   One command at a time. Every byte written takes one read-modify-write
//   through the RAM, issued one per cycle, with req_stall high from the
//   command's transfer until its result is handed over. Clear sweeps the
//   RAM at one entry a cycle. The RAM read port sets the pace.
// Reset
//   Synchronous, active high. Afterwards the engine sweeps zeros through
//   all COLUMNS*PAGES entries with req_stall high.
// Stall
//   The result sits in an output register; the next command is accepted
//   while it waits, and its own result holds in the engine until the
//   register frees up.
module page_framebuffer_draw_engine #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [pfde_pkg::KIND_W-1:0]  req_kind,
   input  logic [pfde_pkg::X_W-1:0]     req_x_left,
   input  logic [pfde_pkg::X_W-1:0]     req_x_right,
   input  logic [pfde_pkg::Y_W-1:0]     req_y_top,
   input  logic [pfde_pkg::Y_W-1:0]     req_y_bottom,
   input  logic [pfde_pkg::PAGE_W-1:0]  req_read_page,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [pfde_pkg::DATA_W-1:0]  rsp_read_data,
   input  logic                         csr_wr_en,
   input  logic [pfde_pkg::MODE_W-1:0]  csr_wr_data
);

   import pfde_pkg::*;

   localparam int CW     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int PW     = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int DEPTH  = COLUMNS * PAGES;
   localparam int AW     = $clog2(DEPTH);
   localparam int NCOL_IN  = 1 << X_W;
   localparam int NPAGE_IN = 1 << PAGE_W;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      VB_TOP,
      VB_BOT,
      VB_MID
   } vphase_type;

   // column and page folding tables, fixed at elaboration
   logic [CW-1:0] col_tab  [NCOL_IN];
   logic [PW-1:0] page_tab [NPAGE_IN];

   for (genvar i = 0; i < NCOL_IN; i++) begin : g_col
      assign col_tab[i] = CW'(i % COLUMNS);
   end
   for (genvar i = 0; i < NPAGE_IN; i++) begin : g_page
      assign page_tab[i] = PW'(i % PAGES);
   end

   function automatic logic [AW-1:0] cell_addr(logic [PW-1:0] pg, logic [CW-1:0] col);
      return AW'(AW'(pg) * AW'(COLUMNS)) + AW'(col);
   endfunction

   // control registers
   state_type         state_ff, state_in;
   logic              boot_ff, boot_in;
   logic [AW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [MODE_W-1:0] mode_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              w_valid_ff;
   logic              fwd_ff, fwd_in;

   // command payload registers
   logic [KIND_W-1:0] kind_ff;
   logic [X_W-1:0]    x_cur_ff, x_cur_in;
   logic [X_W-1:0]    x_right_ff;
   logic [PW-1:0]     page_a_ff;
   logic [PW-1:0]     page_b_ff;
   logic [PW:0]       p_mid_ff, p_mid_in;
   vphase_type        vphase_ff, vphase_in;
   logic [DATA_W-1:0] bit_mask_ff;
   logic [DATA_W-1:0] top_mask_ff;
   logic [DATA_W-1:0] bot_mask_ff;
   logic [DATA_W-1:0] res_ff, res_in;

   // write-back stage registers
   logic              w_write_ff;
   logic [AW-1:0]     w_addr_ff;
   logic [DATA_W-1:0] w_mask_ff;
   logic [DATA_W-1:0] fwd_data_ff;

   // issue side
   logic              accept;
   logic              out_free;
   logic              issue_valid;
   logic              issue_write;
   logic [PW-1:0]     issue_page;
   logic [DATA_W-1:0] issue_mask;
   logic [AW-1:0]     issue_addr;
   logic [PW:0]       p_first;
   logic [PW:0]       p_next;
   logic [PW:0]       p_bot_wide;

   // RAM side
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [DATA_W-1:0] ram_wdata;
   logic [DATA_W-1:0] ram_rdata;
   logic [DATA_W-1:0] old_byte;
   logic [DATA_W-1:0] new_byte;

   assign req_stall     = (state_ff != ST_IDLE);
   assign accept        = req_valid && !req_stall;
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   assign p_bot_wide = {1'b0, page_b_ff};
   assign p_first    = {1'b0, page_a_ff} + 1'b1;
   assign p_next     = p_mid_ff + 1'b1;

   // select the byte and mask for this cycle's read-modify-write
   always_comb begin
      issue_valid = (state_ff == ST_RUN);
      issue_write = (kind_ff != KIND_READ);
      issue_page  = page_a_ff;
      issue_mask  = bit_mask_ff;
      if (kind_ff == KIND_VBAR) begin
         case (vphase_ff)
            VB_TOP: begin
               issue_mask = (page_a_ff == page_b_ff) ? (top_mask_ff & bot_mask_ff)
                                                     : top_mask_ff;
            end
            VB_BOT: begin
               issue_page = page_b_ff;
               issue_mask = bot_mask_ff;
            end
            default: begin
               issue_page = p_mid_ff[PW-1:0];
               issue_mask = FULL_MASK;
            end
         endcase
      end
      issue_addr = cell_addr(issue_page, col_tab[x_cur_ff]);
   end

   // write port: the clear sweep owns it, otherwise the write-back stage
   always_comb begin
      old_byte = fwd_ff ? fwd_data_ff : ram_rdata;
      new_byte = apply_mode(mode_ff, old_byte, w_mask_ff);
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_cnt_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = w_valid_ff && w_write_ff;
         ram_waddr = w_addr_ff;
         ram_wdata = new_byte;
      end
      // forward a write that lands on the entry being read this cycle
      fwd_in = issue_valid && ram_we && (ram_waddr == issue_addr);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      boot_in      = boot_ff;
      clr_cnt_in   = clr_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      x_cur_in     = x_cur_ff;
      p_mid_in     = p_mid_ff;
      vphase_in    = vphase_ff;
      res_in       = res_ff;

      // drop the result once the receiver has taken it
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // capture the byte of a read command
      if (w_valid_ff && !w_write_ff) begin
         res_in = old_byte;
      end

      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == AW'(DEPTH - 1)) begin
               state_in = boot_ff ? ST_IDLE : ST_DONE;
               boot_in  = 1'b0;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               x_cur_in   = req_x_left;
               vphase_in  = VB_TOP;
               res_in     = '0;
               clr_cnt_in = '0;
               case (req_kind)
                  KIND_PIXEL, KIND_VBAR, KIND_HBAR, KIND_READ: state_in = ST_RUN;
                  KIND_CLEAR: state_in = ST_CLEAR;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_RUN: begin
            case (kind_ff)
               KIND_HBAR: begin
                  if (x_cur_ff < x_right_ff) begin
                     x_cur_in = x_cur_ff + 1'b1;
                  end else begin
                     state_in = ST_DRAIN;
                  end
               end
               KIND_VBAR: begin
                  case (vphase_ff)
                     VB_TOP: begin
                        if (page_a_ff == page_b_ff) begin
                           state_in = ST_DRAIN;
                        end else begin
                           vphase_in = VB_BOT;
                        end
                     end
                     VB_BOT: begin
                        p_mid_in = p_first;
                        if (p_first < p_bot_wide) begin
                           vphase_in = VB_MID;
                        end else begin
                           state_in = ST_DRAIN;
                        end
                     end
                     default: begin
                        if (p_next < p_bot_wide) begin
                           p_mid_in = p_next;
                        end else begin
                           state_in = ST_DRAIN;
                        end
                     end
                  endcase
               end
               default: state_in = ST_DRAIN;
            endcase
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         boot_ff      <= 1'b1;
         clr_cnt_ff   <= '0;
         mode_ff      <= MODE_SET;
         rsp_valid_ff <= 1'b0;
         w_valid_ff   <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         boot_ff      <= boot_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         w_valid_ff   <= issue_valid;
         fwd_ff       <= fwd_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
   end

   // payload: command fields, write-back stage, result data
   always_ff @(posedge clock) begin
      x_cur_ff    <= x_cur_in;
      p_mid_ff    <= p_mid_in;
      vphase_ff   <= vphase_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      w_write_ff  <= issue_write;
      w_addr_ff   <= issue_addr;
      w_mask_ff   <= issue_mask;
      fwd_data_ff <= ram_wdata;
      if (accept) begin
         kind_ff     <= req_kind;
         x_right_ff  <= req_x_right;
         page_a_ff   <= (req_kind == KIND_READ) ? page_tab[req_read_page]
                                                : page_tab[req_y_top[Y_W-1:3]];
         page_b_ff   <= page_tab[req_y_bottom[Y_W-1:3]];
         bit_mask_ff <= DATA_W'(1) << req_y_top[2:0];
         top_mask_ff <= FULL_MASK << req_y_top[2:0];
         bot_mask_ff <= DATA_W'((BOT_MASK_SEED << req_y_bottom[2:0]) - BOT_MASK_ONE);
      end
   end

   pfde_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (issue_addr),
      .rd_data (ram_rdata)
   );

   // no write reaches the store while the engine waits for a command
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !ram_we)
      else $error("store written while idle");

   // the clear sweep writes zeros every cycle
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (ram_we && (ram_wdata == '0)))
      else $error("clear sweep wrote non-zero data");

   // a read command never modifies the store
   a_read_no_write: assert property (@(posedge clock) disable iff (reset)
      (w_valid_ff && (kind_ff == KIND_READ)) |-> !ram_we)
      else $error("read command wrote the store");

   // a result is only loaded from the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside done state");

   // commands other than read give a zero result
   a_nonread_zero: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && out_free && (kind_ff != KIND_READ))
      |=> (rsp_data_ff == '0))
      else $error("non-read command gave non-zero data");

endmodule
